### rtl/mlp_forward_pass_softsign_core_assert.svh
// assertion macros shared by the forward pass core
`ifndef MLP_FORWARD_PASS_SOFTSIGN_CORE_ASSERT_SVH
`define MLP_FORWARD_PASS_SOFTSIGN_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MFS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("mfs assertion failed");
`define MFS_ASSERT_NEVER(lbl, cond) \
    `MFS_ASSERT(lbl, !(cond))
`else
`define MFS_ASSERT(lbl, prop)
`define MFS_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/mfs_pkg.sv
// types, constants and codes of the forward pass core
package mfs_pkg;
    localparam int MAX_FEATURES_DEF      = 16;
    localparam int MAX_HIDDEN_WIDTH_DEF  = 16;
    localparam int MAX_HIDDEN_LAYERS_DEF = 4;
    localparam int MAX_OUTPUTS_DEF       = 8;
    localparam int WEIGHT_DEPTH_DEF      = 2048;

    localparam int CNT_W       = 7;
    localparam int LAY_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 11;

    localparam logic [12:0] HALF_Q12 = 13'd2048;
    localparam logic [23:0] ONE_Q12  = 24'd4096;

    localparam logic [2:0] REG_HIDDEN_LAYERS = 3'd0;
    localparam logic [2:0] REG_HIDDEN_WIDTH  = 3'd1;
    localparam logic [2:0] REG_INPUT_WIDTH   = 3'd2;
    localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd3;
    localparam logic [2:0] REG_BIAS_LEVEL    = 3'd4;
    localparam logic [2:0] REG_ACT_RESPONSE  = 3'd5;

    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef enum logic [1:0] {
        ITEM_WEIGHT,
        ITEM_FEATURE,
        ITEM_EVAL
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [15:0]        addr;
        logic [15:0]        value;
        logic [CNT_W-1:0]   fidx;
    } item_t;

    typedef struct packed {
        logic [LAY_W-1:0]   layers;
        logic [CNT_W-1:0]   hidden;
        logic [CNT_W-1:0]   inputs;
        logic [CNT_W-1:0]   outputs;
        logic signed [15:0] bias;
        logic signed [15:0] gain;
    } cfg_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RD,
        B_MUL,
        B_ACC,
        B_SCL,
        B_SHR,
        B_DIV,
        B_WB
    } back_state_t;
endpackage

### rtl/mfs_ram.sv
// generic single write port ram with registered read
module mfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### rtl/mfs_queue.sv
// short item queue between front and back
module mfs_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mfs_pkg::item_t push_item,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output mfs_pkg::item_t head
);
    import mfs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);

    item_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
endmodule

### rtl/mfs_front.sv
// front: takes input words, counts features, tags evaluation triggers
module mfs_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_operation,
    input  logic [10:0]    s_weight_address,
    input  logic [15:0]    s_value,
    input  mfs_pkg::cfg_t  cfg,
    input  logic           q_full,
    output logic           q_push,
    output mfs_pkg::item_t q_item
);
    import mfs_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;
    logic             trigger;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;
    assign cnt_inc = cnt_reg + 1'b1;
    assign trigger = (cnt_inc >= cfg.inputs);

    always_comb begin
        q_item.addr  = 16'(s_weight_address);
        q_item.value = s_value;
        q_item.fidx  = cnt_reg;
        if (s_operation == OP_WEIGHT) begin
            q_item.kind = ITEM_WEIGHT;
        end else if (trigger) begin
            q_item.kind = ITEM_EVAL;
        end else begin
            q_item.kind = ITEM_FEATURE;
        end
        cnt_next = cnt_reg;
        if (q_push && s_operation == OP_FEATURE) begin
            cnt_next = trigger ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end
endmodule

### rtl/mfs_back.sv
// back: weight store, buffers, shared mac, squash divider, result register
`include "mlp_forward_pass_softsign_core_assert.svh"
module mfs_back #(
    parameter int MAX_FEATURES     = mfs_pkg::MAX_FEATURES_DEF,
    parameter int MAX_HIDDEN_WIDTH = mfs_pkg::MAX_HIDDEN_WIDTH_DEF,
    parameter int WEIGHT_DEPTH     = mfs_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  mfs_pkg::cfg_t  cfg,
    input  logic           q_not_empty,
    input  mfs_pkg::item_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [2:0]     m_output_index,
    output logic [12:0]    m_output_value,
    output logic           m_last
);
    import mfs_pkg::*;

    localparam int AW = $clog2(WEIGHT_DEPTH);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int HW = (MAX_HIDDEN_WIDTH > 1) ? $clog2(MAX_HIDDEN_WIDTH) : 1;

    back_state_t        state_reg, state_next;
    logic [LAY_W-1:0]   lay_reg, lay_next;
    logic [CNT_W-1:0]   j_reg, j_next, k_reg, k_next;
    logic [CNT_W-1:0]   nin_reg, nin_next, nout_reg, nout_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic               bank_reg, bank_next;
    logic signed [15:0] opd_reg, opd_next;
    logic signed [31:0] prod_reg, prod_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [47:0] sp_reg, sp_next;
    logic [23:0]        rem_reg, rem_next, den_reg, den_next;
    logic [10:0]        quot_reg, quot_next;
    logic               neg_reg, neg_next;
    logic [3:0]         step_reg, step_next;
    logic               mv_reg, mv_next;
    logic [2:0]         midx_reg, midx_next;
    logic [12:0]        mval_reg, mval_next;
    logic               mlast_reg, mlast_next;

    logic [15:0] feat_reg [MAX_FEATURES];
    logic [15:0] act_reg  [2][MAX_HIDDEN_WIDTH];

    logic               ram_we;
    logic [15:0]        ram_rdata;
    logic signed [15:0] operand;
    logic signed [32:0] sum;
    logic signed [47:0] sp_adj;
    logic signed [23:0] s_val;
    logic [23:0]        s_mag, rem_sh;
    logic [12:0]        result;
    logic               hidden_now, feat_we, act_we, out_free;

    mfs_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weights (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (q_head.addr[AW-1:0]),
        .wdata (q_head.value),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign hidden_now = (lay_reg < cfg.layers);
    assign out_free   = !mv_reg || m_ready;
    assign result     = neg_reg ? HALF_Q12 - 13'(quot_reg) : HALF_Q12 + 13'(quot_reg);
    assign sum        = 33'(acc_reg) + 33'(prod_reg);
    assign sp_adj     = sp_reg + (sp_reg[47] ? 48'sd16777215 : 48'sd0);
    assign s_val      = 24'(sp_adj >>> 24);
    assign s_mag      = s_val[23] ? 24'(-s_val) : 24'(s_val);
    assign rem_sh     = {rem_reg[22:0], 1'b0};

    always_comb begin
        if (k_reg == nin_reg) begin
            operand = cfg.bias;
        end else if (lay_reg == '0) begin
            operand = feat_reg[k_reg[FW-1:0]];
        end else begin
            operand = act_reg[bank_reg][k_reg[HW-1:0]];
        end
    end

    always_comb begin
        state_next = state_reg;
        lay_next   = lay_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        nin_next   = nin_reg;
        nout_next  = nout_reg;
        addr_next  = addr_reg;
        bank_next  = bank_reg;
        opd_next   = opd_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        sp_next    = sp_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        mv_next    = mv_reg && !m_ready;
        midx_next  = midx_reg;
        mval_next  = mval_reg;
        mlast_next = mlast_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        feat_we    = 1'b0;
        act_we     = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_not_empty) begin
                    q_pop = 1'b1;
                    unique case (q_head.kind)
                        ITEM_WEIGHT:  ram_we = 1'b1;
                        ITEM_FEATURE: feat_we = 1'b1;
                        ITEM_EVAL: begin
                            feat_we    = 1'b1;
                            lay_next   = '0;
                            j_next     = '0;
                            k_next     = '0;
                            addr_next  = '0;
                            acc_next   = '0;
                            nin_next   = cfg.inputs;
                            nout_next  = (cfg.layers != '0) ? cfg.hidden : cfg.outputs;
                            state_next = B_RD;
                        end
                        default: ;
                    endcase
                end
            end
            B_RD: begin
                opd_next   = operand;
                state_next = B_MUL;
            end
            B_MUL: begin
                prod_next  = 32'($signed(ram_rdata) * opd_reg);
                addr_next  = addr_reg + 1'b1;
                state_next = B_ACC;
            end
            B_ACC: begin
                if (sum[32] != sum[31]) begin
                    acc_next = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
                end else begin
                    acc_next = sum[31:0];
                end
                if (k_reg == nin_reg) begin
                    state_next = B_SCL;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = B_RD;
                end
            end
            B_SCL: begin
                sp_next    = 48'(acc_reg * cfg.gain);
                state_next = B_SHR;
            end
            B_SHR: begin
                rem_next   = s_mag;
                den_next   = s_mag + ONE_Q12;
                neg_next   = s_val[23];
                quot_next  = '0;
                step_next  = '0;
                state_next = B_DIV;
            end
            B_DIV: begin
                if (rem_sh >= den_reg) begin
                    rem_next  = rem_sh - den_reg;
                    quot_next = {quot_reg[9:0], 1'b1};
                end else begin
                    rem_next  = rem_sh;
                    quot_next = {quot_reg[9:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(DIV_STEPS - 1)) begin
                    state_next = B_WB;
                end
            end
            B_WB: begin
                if (hidden_now || out_free) begin
                    if (hidden_now) begin
                        act_we = 1'b1;
                    end else begin
                        mv_next    = 1'b1;
                        midx_next  = j_reg[2:0];
                        mval_next  = result;
                        mlast_next = (j_reg == nout_reg - 1'b1);
                    end
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = B_RD;
                    if (j_reg == nout_reg - 1'b1) begin
                        j_next = '0;
                        if (hidden_now) begin
                            lay_next  = lay_reg + 1'b1;
                            bank_next = !bank_reg;
                            nin_next  = cfg.hidden;
                            nout_next = (lay_reg + 1'b1 < cfg.layers) ? cfg.hidden
                                                                      : cfg.outputs;
                        end else begin
                            state_next = B_IDLE;
                        end
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            bank_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        lay_reg   <= lay_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        nin_reg   <= nin_next;
        nout_reg  <= nout_next;
        addr_reg  <= addr_next;
        opd_reg   <= opd_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        sp_reg    <= sp_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        step_reg  <= step_next;
        midx_reg  <= midx_next;
        mval_reg  <= mval_next;
        mlast_reg <= mlast_next;
        if (feat_we) begin
            feat_reg[q_head.fidx[FW-1:0]] <= q_head.value;
        end
        if (act_we) begin
            act_reg[!bank_reg][j_reg[HW-1:0]] <= 16'(result);
        end
    end

    assign m_valid        = mv_reg;
    assign m_output_index = midx_reg;
    assign m_output_value = mval_reg;
    assign m_last         = mlast_reg;

    `MFS_ASSERT(a_out_range, m_valid |-> (m_output_value != 13'd0 && m_output_value <= 13'd4095))
    `MFS_ASSERT(a_div_rem, (state_reg == B_DIV) |-> (rem_reg < den_reg))
    `MFS_ASSERT(a_last_idx, (m_valid && m_last) |-> (m_output_index == 3'(cfg.outputs - 1'b1)))
    `MFS_ASSERT_NEVER(a_pop_busy, q_pop && (state_reg != B_IDLE))
endmodule

### rtl/mlp_forward_pass_softsign_core.sv
// top level of the fully connected forward pass core with softsign squash
// Fully connected network forward pass in signed Q4.12. Input words with
// operation 0 write one 16-bit weight into the weight store (layer by layer,
// neuron by neuron, input weights then the bias weight); words with
// operation 1 deliver feature values. A weight or non-final feature word
// is carried out once the back is idle. The final feature word of an
// evaluation starts the pass on one shared multiplier fed from the single
// read port of the weight ram: each neuron reads, multiplies and
// accumulates its inputs (input_width in the first layer, hidden_width
// after it) and the bias, then scales and runs the bit-per-cycle
// softsign divider. Results leave one word per output neuron through a
// result register, last marking the final one; a stalled result holds
// the pass. A two-entry queue lets words be taken during a pass.
module mlp_forward_pass_softsign_core #(
    parameter int MAX_FEATURES      = mfs_pkg::MAX_FEATURES_DEF,
    parameter int MAX_HIDDEN_WIDTH  = mfs_pkg::MAX_HIDDEN_WIDTH_DEF,
    parameter int MAX_HIDDEN_LAYERS = mfs_pkg::MAX_HIDDEN_LAYERS_DEF,
    parameter int MAX_OUTPUTS       = mfs_pkg::MAX_OUTPUTS_DEF,
    parameter int WEIGHT_DEPTH      = mfs_pkg::WEIGHT_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [10:0] s_weight_address,
    input  logic [15:0] s_value,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_output_index,
    output logic [12:0] m_output_value,
    output logic        m_last
);
    import mfs_pkg::*;

    // configuration registers as written
    logic [2:0]  hl_reg;
    logic [4:0]  hw_reg;
    logic [4:0]  iw_reg;
    logic [3:0]  ow_reg;
    logic [15:0] bl_reg;
    logic [15:0] ar_reg;

    cfg_t  cfg;
    item_t q_item, q_head;
    logic  q_push, q_full, q_pop, q_not_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hl_reg <= 3'd1;
            hw_reg <= 5'd8;
            iw_reg <= 5'd4;
            ow_reg <= 4'd2;
            bl_reg <= 16'hf000;
            ar_reg <= 16'h1000;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_HIDDEN_LAYERS: hl_reg <= cfg_wdata[2:0];
                REG_HIDDEN_WIDTH:  hw_reg <= cfg_wdata[4:0];
                REG_INPUT_WIDTH:   iw_reg <= cfg_wdata[4:0];
                REG_OUTPUT_WIDTH:  ow_reg <= cfg_wdata[3:0];
                REG_BIAS_LEVEL:    bl_reg <= cfg_wdata;
                REG_ACT_RESPONSE:  ar_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sizes clamped to the built limits, zero widths read as one
    always_comb begin
        cfg.layers  = (32'(hl_reg) > MAX_HIDDEN_LAYERS) ? LAY_W'(MAX_HIDDEN_LAYERS)
                                                        : LAY_W'(hl_reg);
        cfg.hidden  = (hw_reg == '0) ? CNT_W'(1) :
                      (32'(hw_reg) > MAX_HIDDEN_WIDTH) ? CNT_W'(MAX_HIDDEN_WIDTH)
                                                       : CNT_W'(hw_reg);
        cfg.inputs  = (iw_reg == '0) ? CNT_W'(1) :
                      (32'(iw_reg) > MAX_FEATURES) ? CNT_W'(MAX_FEATURES)
                                                   : CNT_W'(iw_reg);
        cfg.outputs = (ow_reg == '0) ? CNT_W'(1) :
                      (32'(ow_reg) > MAX_OUTPUTS) ? CNT_W'(MAX_OUTPUTS)
                                                  : CNT_W'(ow_reg);
        cfg.bias    = bl_reg;
        cfg.gain    = ar_reg;
    end

    // front classifies each word, back carries it out in order
    mfs_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_weight_address (s_weight_address),
        .s_value          (s_value),
        .cfg              (cfg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_item)
    );

    mfs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mfs_back #(
        .MAX_FEATURES     (MAX_FEATURES),
        .MAX_HIDDEN_WIDTH (MAX_HIDDEN_WIDTH),
        .WEIGHT_DEPTH     (WEIGHT_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_output_index (m_output_index),
        .m_output_value (m_output_value),
        .m_last         (m_last)
    );
endmodule

### tb/tb_top.sv
// self-checking testbench of the forward pass core with softsign squash
module tb_top;
    import mfs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH = 2048;
    localparam int PRELOAD = 24;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [2:0]  index;
        logic [12:0] value;
        logic        last;
    } result_word_t;

    // predictor of the network plus the queue of result words still owed
    class softsign_net_scoreboard;
        logic signed [15:0] weights [STORE_DEPTH];
        logic signed [15:0] features [16];
        int                 features_seen;
        logic [2:0]         n_layers;
        logic [4:0]         n_hidden;
        logic [4:0]         n_inputs;
        logic [3:0]         n_outputs;
        logic signed [15:0] bias;
        logic signed [15:0] gain;
        result_word_t       owed [$];
        int                 errors;

        function new();
            features_seen = 0;
            n_layers = 1;
            n_hidden = 8;
            n_inputs = 4;
            n_outputs = 2;
            bias = -16'sd4096;
            gain = 16'sd4096;
            errors = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [15:0] data);
            case (idx)
                REG_HIDDEN_LAYERS: n_layers = data[2:0];
                REG_HIDDEN_WIDTH:  n_hidden = data[4:0];
                REG_INPUT_WIDTH:   n_inputs = data[4:0];
                REG_OUTPUT_WIDTH:  n_outputs = data[3:0];
                REG_BIAS_LEVEL:    bias = data;
                REG_ACT_RESPONSE:  gain = data;
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function int squash(longint acc);
            longint s, mag, y;
            s = (acc * longint'(gain)) / 64'sd16777216;
            mag = (s < 0) ? -s : s;
            y = (s * 64'sd2048) / (64'sd4096 + mag);
            return int'(y + 64'sd2048);
        endfunction

        function int clampi(int v, int lo, int hi);
            return (v < lo) ? lo : (v > hi) ? hi : v;
        endfunction

        // one accepted input word; evaluation when enough features are in
        function void note_input(logic op, logic [10:0] addr, logic [15:0] value);
            int nl, hw, iw, ow, n_in, n_out, waddr;
            longint acts [16];
            int layer_out [16];
            longint acc;
            result_word_t r;
            if (op == OP_WEIGHT) begin
                weights[addr] = value;
                return;
            end
            nl = clampi(n_layers, 0, 4);
            hw = clampi(n_hidden, 1, 16);
            iw = clampi(n_inputs, 1, 16);
            ow = clampi(n_outputs, 1, 8);
            if (features_seen < 16)
                features[features_seen] = value;
            features_seen++;
            if (features_seen < iw)
                return;
            features_seen = 0;
            for (int k = 0; k < 16; k++)
                acts[k] = longint'(features[k]);
            n_in = iw;
            waddr = 0;
            for (int layer = 0; layer <= nl; layer++) begin
                n_out = (layer < nl) ? hw : ow;
                for (int j = 0; j < n_out; j++) begin
                    acc = 0;
                    for (int k = 0; k < n_in; k++) begin
                        acc = clip32(acc + longint'(weights[waddr % STORE_DEPTH]) * acts[k]);
                        waddr++;
                    end
                    acc = clip32(acc + longint'(weights[waddr % STORE_DEPTH]) * longint'(bias));
                    waddr++;
                    layer_out[j] = squash(acc);
                end
                for (int j = 0; j < n_out; j++)
                    acts[j] = layer_out[j];
                n_in = hw;
            end
            for (int j = 0; j < ow; j++) begin
                r.index = j[2:0];
                r.value = layer_out[j][12:0];
                r.last = (j + 1 == ow);
                owed = {owed, r};
            end
        endfunction

        function void check_result(result_word_t got);
            result_word_t want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: index %0d value %0d last %0d",
                             got.index, got.value, got.last);
                return;
            end
            want = owed.pop_front();
            if (got !== want) begin
                errors++;
                if (errors <= 10)
                    $display("result word wrong: want %0d/%0d/%0d got %0d/%0d/%0d",
                             want.index, want.value, want.last,
                             got.index, got.value, got.last);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = OP_WEIGHT;
    logic [10:0] s_weight_address = '0;
    logic [15:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_output_index;
    logic [12:0] m_output_value;
    logic        m_last;

    softsign_net_scoreboard sb = new();
    // both sides idle at random unless a steady stretch is on
    bit     steady = 1'b0;
    int     hold_cycles = 0;
    longint cycle_count = 0;
    int     random_items = 0;

    mlp_forward_pass_softsign_core dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("mlp_forward_pass_softsign_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off when asked
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn)
                m_ready = 1'b0;
            else if (hold_cycles > 0) begin
                m_ready = 1'b0;
                hold_cycles--;
            end else
                m_ready = steady || ($urandom_range(99) >= 30);
            @(posedge aclk);
            if (m_valid && m_ready)
                sb.check_result('{m_output_index, m_output_value, m_last});
        end
    end

    task automatic send_word(logic op, logic [10:0] addr, logic [15:0] value);
        @(negedge aclk);
        if (!steady && $urandom_range(99) < 30) begin
            s_valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_operation = op;
        s_weight_address = addr;
        s_value = value;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(op, addr, value);
    endtask

    task automatic send_feature(logic [15:0] value);
        send_word(OP_FEATURE, 11'($urandom), value);
    endtask

    // wait for every owed word, then let any queued weight word settle
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic set_network(int nl, int hw, int iw, int ow, logic [15:0] bias_q,
                               logic [15:0] gain_q);
        write_reg(REG_HIDDEN_LAYERS, 16'(nl));
        write_reg(REG_HIDDEN_WIDTH, 16'(hw));
        write_reg(REG_INPUT_WIDTH, 16'(iw));
        write_reg(REG_OUTPUT_WIDTH, 16'(ow));
        write_reg(REG_BIAS_LEVEL, bias_q);
        write_reg(REG_ACT_RESPONSE, gain_q);
    endtask

    // small networks only, so every weight read lies in the preloaded range
    task automatic random_phase(int n_words);
        int nl, hw, iw, ow;
        nl = $urandom_range(2);
        hw = (nl == 2) ? $urandom_range(2, 1) : $urandom_range(3, 1);
        iw = (nl == 2) ? $urandom_range(2, 1) : $urandom_range(3, 1);
        ow = (nl == 2) ? $urandom_range(2, 1) : $urandom_range(3, 1);
        set_network(nl, hw, iw, ow, 16'($urandom), 16'($urandom));
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(99) < 15)
                send_word(OP_WEIGHT, 11'($urandom), 16'($urandom));
            else
                send_feature(16'($urandom));
            random_items++;
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // the lowest weights written first; every network below reads only these
        steady = 1'b1;
        for (int a = 0; a < PRELOAD; a++)
            send_word(OP_WEIGHT, 11'(a), 16'($urandom));
        steady = 1'b0;
        drain();

        // reset bias and gain, narrow sizes, extreme feature values
        write_reg(REG_HIDDEN_WIDTH, 16'd2);
        write_reg(REG_INPUT_WIDTH, 16'd2);
        write_reg(REG_OUTPUT_WIDTH, 16'd2);
        send_feature(16'h8000);
        send_feature(16'h7fff);
        send_feature(16'h0000);
        send_feature(16'hffff);
        drain();

        // positive saturation of the sum: large weights and features
        set_network(0, 1, 3, 1, 16'h7fff, 16'h7fff);
        for (int a = 0; a < 4; a++)
            send_word(OP_WEIGHT, 11'(a), 16'h7fff);
        for (int i = 0; i < 3; i++)
            send_feature(16'h7fff);
        drain();

        // width lowered part way through: the next feature completes it
        set_network(1, 2, 4, 2, 16'h8000, 16'h8000);
        for (int i = 0; i < 3; i++)
            send_feature(16'($urandom));
        drain();
        write_reg(REG_INPUT_WIDTH, 16'd2);
        send_feature(16'h0001);
        drain();

        // sizes out of range clamp: layers and outputs to the top, then widths to one
        set_network(7, 1, 1, 15, 16'h0000, 16'h1000);
        send_feature(16'($urandom));
        send_feature(16'($urandom));
        drain();
        set_network(0, 0, 0, 0, 16'h7fff, 16'h0000);
        send_feature(16'h8000);
        send_feature(16'h1234);
        drain();

        // result side held off while single-feature passes pile up
        set_network(0, 1, 1, 8, 16'($urandom), 16'($urandom));
        hold_cycles = 600;
        steady = 1'b1;
        for (int i = 0; i < 12; i++)
            send_feature(16'($urandom));
        steady = 1'b0;
        drain();

        while (random_items < 40) begin
            steady = ($urandom_range(4) == 0);
            random_phase($urandom_range(15, 8));
        end
        steady = 1'b0;

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("mlp_forward_pass_softsign_core: match");
        else
            $display("mlp_forward_pass_softsign_core: mismatch");
        $finish;
    end
endmodule
